// ===== hw/rtl/nearest_rectangle_select_core_defines.svh =====
// Assertion shorthands for the nearest rectangle select block.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef NEAREST_RECTANGLE_SELECT_CORE_DEFINES_SVH
`define NEAREST_RECTANGLE_SELECT_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define NRS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nrs assertion failed");

// Next-cycle implication, checked outside reset
`define NRS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nrs assertion failed");

`endif

// ===== hw/rtl/nrs_pkg.sv =====
`default_nettype none

package nrs_pkg;

  // Table depth default
  localparam int MAX_SCREENS_DEF = 8;

  // Field widths
  localparam int COORD_W  = 16;
  localparam int LABEL_W  = 8;
  localparam int INDEX_W  = 3;
  localparam int COUNT_W  = 4;
  localparam int GAP_W    = 16;
  localparam int SQ_W     = 2 * GAP_W;
  localparam int DIST_W   = SQ_W + 1;
  localparam int IN_DW    = 112;
  localparam int OUT_DW   = 48;

  // Item kinds carried on in_tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] height;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } nrs_entry_t;

  localparam int ENTRY_W = $bits(nrs_entry_t);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GAP,
    S_SQX,
    S_SQY,
    S_ACC,
    S_DONE
  } nrs_state_t;

  // Step strobes from the sequencer to the distance unit
  typedef struct packed {
    logic gap_en;
    logic sqx_en;
    logic sqy_en;
  } nrs_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nearest_rectangle_select_core.sv =====
// Nearest rectangle select core.
// Input channel (in_*): in_tuser = 0 writes table entry entry_index with the
// rectangle and label in in_tdata; in_tuser = 1 queries the point point_x,
// point_y. A write takes effect at its accept edge and gives no result.
// Result channel (out_*): one item per query: label and squared distance of
// the nearest of entries 0 .. screen_count-1 (lowest index wins a tie);
// out_tuser (found) is 0 with zero data when no entry is active.
// cfg_wr_en/cfg_wr_data write screen_count; the user must write it only while
// the core is idle, which the core itself does not enforce. For each active
// entry the sequencer steps through RAM read, gap, square x, square y and
// compare; the one shared squarer serves both squares. out_tvalid rises as
// the sequencer returns to idle, and in_tready returns with it. in_tready is
// high only when the sequencer is idle; a write does not leave the idle state.
// A finished result sits in the output register; if the receiver stalls, the
// sequencer holds in its final step until the register is free, and a new
// item can be accepted while the last result still waits.
// Reset clears the sequencer, the output valid and screen_count to 0; table
// contents are undefined until written.
`default_nettype none

module nearest_rectangle_select_core import nrs_pkg::*; #(
  parameter int MAX_SCREENS = MAX_SCREENS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_wr_en,
  input  wire logic [COUNT_W-1:0]   cfg_wr_data,  // screen_count
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // [2:0] entry_index, [18:3] new_left, [34:19] new_top, [50:35] new_width,
  // [66:51] new_height, [74:67] new_label, [90:75] point_x, [106:91] point_y
  input  wire logic [IN_DW-1:0]     in_tdata,
  input  wire logic                 in_tuser,     // cmd
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // [7:0] nearest_label, [40:8] nearest_distance
  output logic      [OUT_DW-1:0]    out_tdata,
  output logic                      out_tuser     // found
);

`include "nearest_rectangle_select_core_defines.svh"

  localparam int IDX_W = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
  localparam int CNT_W = $clog2(MAX_SCREENS + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  // Input field split
  logic [INDEX_W-1:0] f_index;
  logic [COORD_W-1:0] f_px, f_py;
  nrs_entry_t         f_entry;

  assign f_index        = in_tdata[2:0];
  assign f_entry.left   = in_tdata[18:3];
  assign f_entry.top    = in_tdata[34:19];
  assign f_entry.width  = in_tdata[50:35];
  assign f_entry.height = in_tdata[66:51];
  assign f_entry.label  = in_tdata[74:67];
  assign f_px           = in_tdata[90:75];
  assign f_py           = in_tdata[106:91];

  logic in_fire, out_fire;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  // Configuration register
  logic [COUNT_W-1:0] cfg_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= '0;
    end else if (cfg_wr_en) begin
      cfg_count_r <= cfg_wr_data;
    end
  end

  // Active entry count, clamped to the table depth
  logic [CMP_W-1:0] cnt_ext;
  logic [CNT_W-1:0] count_clamped;

  assign cnt_ext       = CMP_W'(cfg_count_r);
  assign count_clamped = (cnt_ext > CMP_W'(MAX_SCREENS)) ? CNT_W'(MAX_SCREENS)
                                                          : CNT_W'(cnt_ext);

  // Table RAM
  logic       ram_we;
  nrs_entry_t ram_rdata;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  assign ram_we = in_fire && (in_tuser == CMD_WRITE) &&
                  (7'(f_index) < 7'(MAX_SCREENS));

  nrs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SCREENS),
    .AW    (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(f_index)),
    .wdata (f_entry),
    .raddr (idx_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Query registers
  logic [COORD_W-1:0] px_r, py_r;
  logic [CNT_W-1:0]   count_r;

  always_ff @(posedge clk) begin
    if (in_fire && (in_tuser == CMD_QUERY)) begin
      px_r    <= f_px;
      py_r    <= f_py;
      count_r <= count_clamped;
    end
  end

  // Distance unit
  nrs_ctrl_t         ctrl;
  logic [DIST_W-1:0] sq_dist;

  nrs_dist_unit u_dist (
    .clk     (clk),
    .ctrl    (ctrl),
    .px      (px_r),
    .py      (py_r),
    .ent     (ram_rdata),
    .sq_dist (sq_dist)
  );

  // Label of the entry under evaluation, held from the RAM read
  logic [LABEL_W-1:0] cur_label_r;

  always_ff @(posedge clk) begin
    if (ctrl.gap_en) begin
      cur_label_r <= ram_rdata.label;
    end
  end

  // Sequencer
  nrs_state_t state_r, state_nxt;
  logic       acc_en, best_clr, out_load, last_entry;

  assign last_entry = (idx_r + CNT_W'(1)) >= count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ctrl      = '0;
    acc_en    = 1'b0;
    best_clr  = 1'b0;
    out_load  = 1'b0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && (in_tuser == CMD_QUERY)) begin
          best_clr  = 1'b1;
          idx_nxt   = '0;
          state_nxt = (count_clamped == '0) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_GAP;
      end
      S_GAP: begin
        ctrl.gap_en = 1'b1;
        state_nxt   = S_SQX;
      end
      S_SQX: begin
        ctrl.sqx_en = 1'b1;
        state_nxt   = S_SQY;
      end
      S_SQY: begin
        ctrl.sqy_en = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        acc_en = 1'b1;
        if (last_entry) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_READ;
        end
      end
      S_DONE: begin
        if (!out_tvalid || out_tready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Running best; strict compare keeps the lowest index on a tie
  logic               have_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [LABEL_W-1:0] best_l_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
    end else if (best_clr) begin
      have_r <= 1'b0;
    end else if (acc_en) begin
      have_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (best_clr) begin
      best_d_r <= '0;
      best_l_r <= '0;
    end else if (acc_en && (!have_r || sq_dist < best_d_r)) begin
      best_d_r <= sq_dist;
      best_l_r <= cur_label_r;
    end
  end

  // Output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [OUT_DW-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= have_r;
      out_data_r  <= OUT_DW'({best_d_r, best_l_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_data_r;

  // Checks
  `NRS_ASSERT_IMP(a_read_in_range, state_r == S_READ, idx_r < count_r)
  `NRS_ASSERT_NXT(a_acc_sets_have, state_r == S_ACC, have_r)
  `NRS_ASSERT_IMP(a_empty_is_zero, out_tvalid && !out_tuser, out_tdata == '0)

endmodule

`default_nettype wire

// ===== hw/rtl/nrs_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data
module nrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nrs_dist_unit.sv =====
`default_nettype none

// Squared point-to-rectangle distance, one step per strobe.
// A single 16x16 squarer is shared between the x and y gaps.
module nrs_dist_unit import nrs_pkg::*; (
  input  wire logic               clk,
  input  wire nrs_ctrl_t          ctrl,
  input  wire logic [COORD_W-1:0] px,
  input  wire logic [COORD_W-1:0] py,
  input  wire nrs_entry_t         ent,
  output logic      [DIST_W-1:0]  sq_dist
);

  logic [GAP_W-1:0] dx_r, dy_r;
  logic [SQ_W-1:0]  sq_x_r, sq_y_r;
  logic [GAP_W-1:0] mul_in;
  logic [SQ_W-1:0]  prod;

  // Gap from p to the span [lo, lo + size - 1]; a zero size counts as one
  function automatic logic [GAP_W-1:0] axis_gap(
    input logic [COORD_W-1:0] p,
    input logic [COORD_W-1:0] lo,
    input logic [COORD_W-1:0] size
  );
    logic signed [COORD_W+1:0] p_e, lo_e, hi_e, diff;
    logic [COORD_W-1:0]        span;
    span = (size == '0) ? '0 : size - COORD_W'(1);
    p_e  = $signed({{2{p[COORD_W-1]}}, p});
    lo_e = $signed({{2{lo[COORD_W-1]}}, lo});
    hi_e = lo_e + $signed({2'b00, span});
    if (p_e < lo_e) begin
      diff = lo_e - p_e;
    end else if (p_e > hi_e) begin
      diff = p_e - hi_e;
    end else begin
      diff = '0;
    end
    return diff[GAP_W-1:0];
  endfunction

  // Shared squarer
  assign mul_in = ctrl.sqy_en ? dy_r : dx_r;
  assign prod   = mul_in * mul_in;

  always_ff @(posedge clk) begin
    if (ctrl.gap_en) begin
      dx_r <= axis_gap(px, ent.left, ent.width);
      dy_r <= axis_gap(py, ent.top, ent.height);
    end
    if (ctrl.sqx_en) begin
      sq_x_r <= prod;
    end
    if (ctrl.sqy_en) begin
      sq_y_r <= prod;
    end
  end

  assign sq_dist = {1'b0, sq_x_r} + {1'b0, sq_y_r};

endmodule

`default_nettype wire
